// ===== rtl/exptok_pkg.sv =====
`timescale 1ns / 1ps

package exptok_pkg;

  // Line geometry
  localparam int LINE_MAX_CHARS = 1024;
  localparam int POS_W          = $clog2(LINE_MAX_CHARS + 1);

  // Field widths
  localparam int CH_W      = 8;
  localparam int KIND_W    = 5;
  localparam int START_W   = 10;
  localparam int LEN_W     = 11;
  localparam int START_MAX = (2 ** START_W) - 1;
  localparam int LEN_MAX   = (2 ** LEN_W) - 1;

  // Keyword capture buffer
  localparam int KW_DEPTH = 6;
  localparam int KW_IDX_W = $clog2(KW_DEPTH);

  // Result queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [KIND_W-1:0] {
    KIND_INT       = 5'd0,
    KIND_DOUBLE    = 5'd1,
    KIND_VAR       = 5'd2,
    KIND_SIN       = 5'd3,
    KIND_COS       = 5'd4,
    KIND_TAN       = 5'd5,
    KIND_ARCSIN    = 5'd6,
    KIND_ARCCOS    = 5'd7,
    KIND_ARCTAN    = 5'd8,
    KIND_LOG       = 5'd9,
    KIND_STRING    = 5'd10,
    KIND_EQEQ      = 5'd11,
    KIND_EQ        = 5'd12,
    KIND_GE        = 5'd13,
    KIND_GT        = 5'd14,
    KIND_LE        = 5'd15,
    KIND_LT        = 5'd16,
    KIND_OROR      = 5'd17,
    KIND_LPAREN    = 5'd18,
    KIND_RPAREN    = 5'd19,
    KIND_LBRACKET  = 5'd20,
    KIND_RBRACKET  = 5'd21,
    KIND_CARET     = 5'd22,
    KIND_PLUS      = 5'd23,
    KIND_MINUS     = 5'd24,
    KIND_STAR      = 5'd25,
    KIND_SLASH     = 5'd26,
    KIND_COMMA     = 5'd27,
    KIND_NEWLINE   = 5'd28,
    KIND_ERR_CHAR  = 5'd29,
    KIND_ERR_BAR   = 5'd30,
    KIND_ERR_UNTERM = 5'd31
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   length;
    logic               last;
  } tok_t;

  // Up to two tokens produced by one character
  typedef struct packed {
    logic [1:0] n;
    tok_t       tok0;
    tok_t       tok1;
  } lex_out_t;

  function automatic logic [START_W-1:0] sat_start(input logic [POS_W-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return (w > 32'(START_MAX)) ? START_W'(START_MAX) : START_W'(w);
  endfunction

  function automatic logic [LEN_W-1:0] sat_len(input logic [POS_W-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return (w > 32'(LEN_MAX)) ? LEN_W'(LEN_MAX) : LEN_W'(w);
  endfunction

endpackage

// ===== rtl/exptok_lexer.sv =====
`timescale 1ns / 1ps

module exptok_lexer
  import exptok_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            fire,
  input  logic [CH_W-1:0] ch,
  output lex_out_t        res
);

  typedef enum logic [7:0] {
    M_IDLE   = 8'b0000_0001,
    M_NUMBER = 8'b0000_0010,
    M_WORD   = 8'b0000_0100,
    M_STRING = 8'b0000_1000,
    M_EQ     = 8'b0001_0000,
    M_GT     = 8'b0010_0000,
    M_LT     = 8'b0100_0000,
    M_BAR    = 8'b1000_0000
  } mode_t;

  mode_t            mode, mode_next;
  logic [POS_W-1:0] pos, pos_next;
  logic [POS_W-1:0] tbeg, tbeg_next;
  logic [POS_W-1:0] cnt, cnt_next;
  logic             dot, dot_next;
  logic [CH_W-1:0]  kw [KW_DEPTH];

  logic                kw_we;
  logic [KW_IDX_W-1:0] kw_idx;

  logic             pre_v, st_v, fresh, skip, nl;
  kind_t            pre_kind, st_kind, two_kind, word_kind;
  logic [POS_W-1:0] pre_start, pre_len;
  logic [CH_W-1:0]  second;

  function automatic logic is_alpha(input logic [CH_W-1:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(input logic [CH_W-1:0] c);
    return c >= "0" && c <= "9";
  endfunction

  // Keyword match on the captured leading characters
  always_comb begin
    word_kind = KIND_VAR;
    if (cnt == POS_W'(3)) begin
      if (kw[0] == "s" && kw[1] == "i" && kw[2] == "n") word_kind = KIND_SIN;
      else if (kw[0] == "c" && kw[1] == "o" && kw[2] == "s") word_kind = KIND_COS;
      else if (kw[0] == "t" && kw[1] == "a" && kw[2] == "n") word_kind = KIND_TAN;
      else if (kw[0] == "l" && kw[1] == "o" && kw[2] == "g") word_kind = KIND_LOG;
    end else if (cnt == POS_W'(KW_DEPTH)) begin
      if (kw[0] == "a" && kw[1] == "r" && kw[2] == "c") begin
        if (kw[3] == "s" && kw[4] == "i" && kw[5] == "n") word_kind = KIND_ARCSIN;
        else if (kw[3] == "c" && kw[4] == "o" && kw[5] == "s") word_kind = KIND_ARCCOS;
        else if (kw[3] == "t" && kw[4] == "a" && kw[5] == "n") word_kind = KIND_ARCTAN;
      end
    end
  end

  always_comb begin
    case (mode)
      M_GT:    two_kind = KIND_GE;
      M_LT:    two_kind = KIND_LE;
      M_BAR:   two_kind = KIND_OROR;
      default: two_kind = KIND_EQEQ;
    endcase
  end

  always_comb begin
    nl        = (ch == 8'h0A) || (ch == 8'h0D);
    skip      = !nl && (32'(pos) >= 32'(LINE_MAX_CHARS));
    second    = (mode == M_BAR) ? "|" : "=";
    mode_next = mode;
    pos_next  = pos;
    tbeg_next = tbeg;
    cnt_next  = cnt;
    dot_next  = dot;
    kw_we     = 1'b0;
    kw_idx    = cnt[KW_IDX_W-1:0];
    pre_v     = 1'b0;
    pre_kind  = KIND_INT;
    pre_start = tbeg;
    pre_len   = cnt;
    st_v      = 1'b0;
    st_kind   = KIND_ERR_CHAR;
    fresh     = 1'b1;

    if (fire && !skip) begin
      // Finish or extend the open token
      case (mode)
        M_NUMBER: begin
          if (is_digit(ch) || ch == ".") begin
            if (ch == ".") dot_next = 1'b1;
            cnt_next = cnt + POS_W'(1);
            fresh    = 1'b0;
          end else begin
            pre_v    = 1'b1;
            pre_kind = dot ? KIND_DOUBLE : KIND_INT;
          end
        end
        M_WORD: begin
          if (is_alpha(ch) || is_digit(ch) || ch == "_") begin
            kw_we    = (32'(cnt) < 32'(KW_DEPTH));
            cnt_next = cnt + POS_W'(1);
            fresh    = 1'b0;
          end else begin
            pre_v    = 1'b1;
            pre_kind = word_kind;
          end
        end
        M_STRING: begin
          if (ch == "\"") begin
            pre_v     = 1'b1;
            pre_kind  = KIND_STRING;
            mode_next = M_IDLE;
            fresh     = 1'b0;
          end else if (nl) begin
            pre_v    = 1'b1;
            pre_kind = KIND_ERR_UNTERM;
          end else begin
            cnt_next = cnt + POS_W'(1);
            fresh    = 1'b0;
          end
        end
        M_EQ, M_GT, M_LT, M_BAR: begin
          pre_v = 1'b1;
          if (ch == second) begin
            pre_kind  = two_kind;
            pre_len   = POS_W'(2);
            mode_next = M_IDLE;
            fresh     = 1'b0;
          end else begin
            pre_kind = (mode == M_BAR) ? KIND_ERR_BAR : kind_t'(two_kind + KIND_W'(1));
            pre_len  = POS_W'(1);
          end
        end
        default: begin
        end
      endcase

      // Character with no token open
      if (fresh) begin
        mode_next = M_IDLE;
        tbeg_next = pos;
        cnt_next  = POS_W'(1);
        dot_next  = 1'b0;
        if (ch == " " || ch == 8'h09) begin
          st_v = 1'b0;
        end else if (is_alpha(ch)) begin
          mode_next = M_WORD;
          kw_we     = 1'b1;
          kw_idx    = '0;
        end else if (is_digit(ch)) begin
          mode_next = M_NUMBER;
        end else begin
          st_v = 1'b1;
          case (ch)
            "=":   begin st_v = 1'b0; mode_next = M_EQ;  end
            ">":   begin st_v = 1'b0; mode_next = M_GT;  end
            "<":   begin st_v = 1'b0; mode_next = M_LT;  end
            "|":   begin st_v = 1'b0; mode_next = M_BAR; end
            "(":   st_kind = KIND_LPAREN;
            ")":   st_kind = KIND_RPAREN;
            "[":   st_kind = KIND_LBRACKET;
            "]":   st_kind = KIND_RBRACKET;
            "^":   st_kind = KIND_CARET;
            "+":   st_kind = KIND_PLUS;
            "-":   st_kind = KIND_MINUS;
            "*":   st_kind = KIND_STAR;
            "/":   st_kind = KIND_SLASH;
            ",":   st_kind = KIND_COMMA;
            "\"": begin
              st_v      = 1'b0;
              mode_next = M_STRING;
              tbeg_next = pos + POS_W'(1);
              cnt_next  = '0;
            end
            8'h0A, 8'h0D: st_kind = KIND_NEWLINE;
            default: st_kind = KIND_ERR_CHAR;
          endcase
        end
      end

      if (nl) begin
        mode_next = M_IDLE;
        pos_next  = '0;
      end else begin
        pos_next = pos + POS_W'(1);
      end
    end
  end

  // Pack results; the later token carries the end-of-run flag
  always_comb begin
    res.n           = 2'(pre_v) + 2'(st_v);
    res.tok1.kind   = st_kind;
    res.tok1.start  = sat_start(pos);
    res.tok1.length = LEN_W'(1);
    res.tok1.last   = 1'b1;
    if (pre_v) begin
      res.tok0.kind   = pre_kind;
      res.tok0.start  = sat_start(pre_start);
      res.tok0.length = sat_len(pre_len);
      res.tok0.last   = !st_v;
    end else begin
      res.tok0 = res.tok1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE;
      pos  <= '0;
      tbeg <= '0;
      cnt  <= '0;
      dot  <= 1'b0;
    end else begin
      mode <= mode_next;
      pos  <= pos_next;
      tbeg <= tbeg_next;
      cnt  <= cnt_next;
      dot  <= dot_next;
    end
  end

  always_ff @(posedge clk) begin
    if (kw_we) kw[kw_idx] <= ch;
  end

endmodule

// ===== rtl/exptok_fifo.sv =====
`timescale 1ns / 1ps

module exptok_fifo
  import exptok_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  lex_out_t push,
  input  logic     pop,
  output tok_t     head,
  output logic     not_empty,
  output logic     room2
);

  tok_t                  mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr, rd;
  logic [FIFO_CNT_W-1:0] count;

  assign not_empty = (count != '0);
  assign room2     = (32'(count) <= 32'(FIFO_DEPTH - 2));
  assign head      = mem[rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr    <= '0;
      rd    <= '0;
      count <= '0;
    end else begin
      wr    <= wr + FIFO_PTR_W'(push.n);
      rd    <= rd + FIFO_PTR_W'(pop);
      count <= count + FIFO_CNT_W'(push.n) - FIFO_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) mem[wr] <= push.tok0;
    if (push.n == 2'd2) mem[wr + FIFO_PTR_W'(1)] <= push.tok1;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= 32'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("result queue popped while empty");
`endif

endmodule

// ===== rtl/expression_tokenizer_top.sv =====
`timescale 1ns / 1ps

// Characters pass the input register, the combinational scanner and then the result queue.
// Throughput: one character per cycle while the queue has room for two tokens; a character
// that ends a token and is one itself emits two, one per cycle while out_stall is low.
// Reset (rst, synchronous, active high): empties the input stage and the result queue and
// returns the scanner to idle at line position zero.
module expression_tokenizer_top
  import exptok_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // character channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [CH_W-1:0]    ch,
  // token channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [KIND_W-1:0]  token_kind,
  output logic [START_W-1:0] token_start,
  output logic [LEN_W-1:0]   token_length,
  output logic               last_of_run
);

  // Input register: holds one character transaction in front of the scanner
  logic            stage_valid;
  logic [CH_W-1:0] stage_ch;

  logic     fire;
  logic     room2;
  logic     pop;
  lex_out_t lex_res;
  tok_t     head;

  // The scanner consumes the staged character only when the queue can take two tokens
  assign fire     = stage_valid && room2;
  assign in_stall = stage_valid && !room2;
  assign pop      = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!in_stall) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) stage_ch <= ch;
  end

  // Mode logic, position tracking and keyword compare
  exptok_lexer u_lexer (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .ch   (stage_ch),
    .res  (lex_res)
  );

  // Result queue decouples two-token characters from the output handshake
  exptok_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (lex_res),
    .pop       (pop),
    .head      (head),
    .not_empty (out_valid),
    .room2     (room2)
  );

  assign token_kind   = head.kind;
  assign token_start  = head.start;
  assign token_length = head.length;
  assign last_of_run  = head.last;

`ifndef SYNTHESIS
  a_no_result_when_idle: assert property (@(posedge clk) disable iff (rst)
    !fire |-> lex_res.n == 2'd0)
    else $error("tokens produced without a character transaction");

  a_pair_flags: assert property (@(posedge clk) disable iff (rst)
    lex_res.n == 2'd2 |-> !lex_res.tok0.last && lex_res.tok1.last)
    else $error("two-token run has wrong end flags");

  a_single_flag: assert property (@(posedge clk) disable iff (rst)
    lex_res.n == 2'd1 |-> lex_res.tok0.last)
    else $error("single token lacks end flag");

  a_empty_after_reset: assert property (@(posedge clk)
    !rst && $past(rst) |-> !out_valid)
    else $error("output valid right after reset");
`endif

endmodule

// ===== dv/expression_tokenizer_checker.sv =====
`timescale 1ns / 1ps

module expression_tokenizer_checker
  import exptok_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [CH_W-1:0]    ch,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [KIND_W-1:0]  token_kind,
  input  logic [START_W-1:0] token_start,
  input  logic [LEN_W-1:0]   token_length,
  input  logic               last_of_run,
  output int                 fail_count,
  output int                 tokens_owed
);

  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;

  typedef enum logic [3:0] {
    SCAN_IDLE, SCAN_NUMBER, SCAN_WORD, SCAN_STRING,
    SCAN_EQ, SCAN_GT, SCAN_LT, SCAN_BAR
  } scan_mode_t;

  scan_mode_t       mode;
  logic [POS_W-1:0] line_pos;
  logic [POS_W-1:0] tok_begin;
  logic [POS_W-1:0] tok_count;
  logic             dot_seen;
  logic [7:0]       kw_buf [KW_DEPTH];
  tok_t             owed_q [$];
  tok_t             char_toks [$];
  int               fails = 0;

  assign fail_count = fails;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  // start saturates at 1023; length cannot pass 2047 at this line size
  function automatic void add_tok(input kind_t k, input logic [POS_W-1:0] s,
                                  input logic [POS_W-1:0] l);
    tok_t t;
    t.kind   = k;
    t.start  = (s > POS_W'(START_MAX)) ? '1 : s[START_W-1:0];
    t.length = LEN_W'(l);
    t.last   = 1'b0;
    char_toks.push_back(t);
  endfunction

  function automatic kind_t word_kind();
    logic [23:0] w3;
    logic [47:0] w6;
    w3 = {kw_buf[0], kw_buf[1], kw_buf[2]};
    w6 = {w3, kw_buf[3], kw_buf[4], kw_buf[5]};
    if (tok_count == 3) begin
      case (w3)
        "sin": return KIND_SIN;
        "cos": return KIND_COS;
        "tan": return KIND_TAN;
        "log": return KIND_LOG;
        default: ;
      endcase
    end
    if (tok_count == 6) begin
      case (w6)
        "arcsin": return KIND_ARCSIN;
        "arccos": return KIND_ARCCOS;
        "arctan": return KIND_ARCTAN;
        default: ;
      endcase
    end
    return KIND_VAR;
  endfunction

  // character seen with no token open
  function automatic void open_token(input logic [7:0] c, input logic [POS_W-1:0] p);
    mode      = SCAN_IDLE;
    tok_begin = p;
    tok_count = POS_W'(1);
    dot_seen  = 1'b0;
    if (is_letter(c)) begin
      mode      = SCAN_WORD;
      kw_buf[0] = c;
    end else if (is_digit(c)) begin
      mode = SCAN_NUMBER;
    end else begin
      case (c)
        " ", CH_TAB: ;
        "=": mode = SCAN_EQ;
        ">": mode = SCAN_GT;
        "<": mode = SCAN_LT;
        "|": mode = SCAN_BAR;
        "(": add_tok(KIND_LPAREN, p, POS_W'(1));
        ")": add_tok(KIND_RPAREN, p, POS_W'(1));
        "[": add_tok(KIND_LBRACKET, p, POS_W'(1));
        "]": add_tok(KIND_RBRACKET, p, POS_W'(1));
        "^": add_tok(KIND_CARET, p, POS_W'(1));
        "+": add_tok(KIND_PLUS, p, POS_W'(1));
        "-": add_tok(KIND_MINUS, p, POS_W'(1));
        "*": add_tok(KIND_STAR, p, POS_W'(1));
        "/": add_tok(KIND_SLASH, p, POS_W'(1));
        ",": add_tok(KIND_COMMA, p, POS_W'(1));
        "\"": begin
          mode      = SCAN_STRING;
          tok_begin = p + POS_W'(1);
          tok_count = '0;
        end
        CH_LF, CH_CR: add_tok(KIND_NEWLINE, p, POS_W'(1));
        default: add_tok(KIND_ERR_CHAR, p, POS_W'(1));
      endcase
    end
  endfunction

  function automatic void predict_char(input logic [7:0] c);
    logic [POS_W-1:0] p;
    logic             nl;
    logic             fresh;
    logic [7:0]       second;
    kind_t            pair_kind;
    kind_t            lone_kind;
    tok_t             t;
    p     = line_pos;
    nl    = (c == CH_LF) || (c == CH_CR);
    fresh = 1'b1;
    char_toks.delete();
    // past the line limit only a newline does anything
    if (!nl && p >= POS_W'(LINE_MAX_CHARS)) return;
    case (mode)
      SCAN_NUMBER: begin
        if (is_digit(c) || c == ".") begin
          if (c == ".") dot_seen = 1'b1;
          tok_count++;
          fresh = 1'b0;
        end else begin
          add_tok(dot_seen ? KIND_DOUBLE : KIND_INT, tok_begin, tok_count);
        end
      end
      SCAN_WORD: begin
        if (is_letter(c) || is_digit(c) || c == "_") begin
          if (tok_count < KW_DEPTH) kw_buf[tok_count[KW_IDX_W-1:0]] = c;
          tok_count++;
          fresh = 1'b0;
        end else begin
          add_tok(word_kind(), tok_begin, tok_count);
        end
      end
      SCAN_STRING: begin
        if (c == "\"") begin
          add_tok(KIND_STRING, tok_begin, tok_count);
          mode  = SCAN_IDLE;
          fresh = 1'b0;
        end else if (nl) begin
          add_tok(KIND_ERR_UNTERM, tok_begin, tok_count);
        end else begin
          tok_count++;
          fresh = 1'b0;
        end
      end
      SCAN_EQ, SCAN_GT, SCAN_LT, SCAN_BAR: begin
        case (mode)
          SCAN_EQ: begin pair_kind = KIND_EQEQ; lone_kind = KIND_EQ; end
          SCAN_GT: begin pair_kind = KIND_GE;   lone_kind = KIND_GT; end
          SCAN_LT: begin pair_kind = KIND_LE;   lone_kind = KIND_LT; end
          default: begin pair_kind = KIND_OROR; lone_kind = KIND_ERR_BAR; end
        endcase
        second = (mode == SCAN_BAR) ? "|" : "=";
        if (c == second) begin
          add_tok(pair_kind, tok_begin, POS_W'(2));
          mode  = SCAN_IDLE;
          fresh = 1'b0;
        end else begin
          add_tok(lone_kind, tok_begin, POS_W'(1));
        end
      end
      default: ;
    endcase
    if (fresh) open_token(c, p);
    if (nl) begin
      mode     = SCAN_IDLE;
      line_pos = '0;
    end else begin
      line_pos = p + POS_W'(1);
    end
    if (char_toks.size() != 0) begin
      t      = char_toks.pop_back();
      t.last = 1'b1;
      char_toks.push_back(t);
    end
    foreach (char_toks[i]) owed_q.push_back(char_toks[i]);
  endfunction

  always @(posedge clk) begin
    tok_t want;
    if (rst) begin
      mode      = SCAN_IDLE;
      line_pos  = '0;
      tok_begin = '0;
      tok_count = '0;
      dot_seen  = 1'b0;
      foreach (kw_buf[i]) kw_buf[i] = '0;
      owed_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (owed_q.size() == 0) begin
          if (fails < 10)
            $display("unexpected token: kind %0d start %0d length %0d last %0d",
                     token_kind, token_start, token_length, last_of_run);
          fails++;
        end else begin
          want = owed_q.pop_front();
          if (token_kind !== want.kind || token_start !== want.start ||
              token_length !== want.length || last_of_run !== want.last) begin
            if (fails < 10)
              $display({"token mismatch: expected kind %0d start %0d length %0d last %0d,",
                        " got kind %0d start %0d length %0d last %0d"},
                       want.kind, want.start, want.length, want.last,
                       token_kind, token_start, token_length, last_of_run);
            fails++;
          end
        end
      end
      if (in_valid && !in_stall) predict_char(ch);
    end
    tokens_owed = owed_q.size();
  end

endmodule

// ===== dv/expression_tokenizer_top_tb.sv =====
`timescale 1ns / 1ps

module expression_tokenizer_top_tb;
  import exptok_pkg::*;

  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic [CH_W-1:0]    ch        = '0;
  logic               out_stall = 1'b0;
  logic               in_stall;
  logic               out_valid;
  logic [KIND_W-1:0]  token_kind;
  logic [START_W-1:0] token_start;
  logic [LEN_W-1:0]   token_length;
  logic               last_of_run;

  int fail_count;
  int tokens_owed;

  // sender bookkeeping: accepted characters and whether gaps are on right now
  int chars_sent = 0;
  bit send_gaps  = 1'b0;

  // token source material for the random lines
  string op_chars     = "=<>|()[]^+-*/,";
  string op_pairs [4] = '{"==", ">=", "<=", "||"};
  string kw_names [7] = '{"sin", "cos", "tan", "arcsin", "arccos", "arctan", "log"};

  always #5 clk = ~clk;

  expression_tokenizer_top dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .ch           (ch),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .token_kind   (token_kind),
    .token_start  (token_start),
    .token_length (token_length),
    .last_of_run  (last_of_run)
  );

  // Watches both channels, predicts every token and compares in order.
  expression_tokenizer_checker token_check (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .ch           (ch),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .token_kind   (token_kind),
    .token_start  (token_start),
    .token_length (token_length),
    .last_of_run  (last_of_run),
    .fail_count   (fail_count),
    .tokens_owed  (tokens_owed)
  );

  // One character transaction. Called at a rising edge; returns at the edge
  // where the character was taken. in_valid stays high when the next gap is
  // zero, so back-to-back characters never drop valid.
  task automatic send_char(input logic [7:0] c);
    int gap;
    gap = send_gaps ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    ch       <= c;
    @(posedge clk);
    // in_stall read here is the value the block saw at this edge
    while (in_stall) @(posedge clk);
    chars_sent++;
    // switch gaps on and off in stretches
    if (chars_sent % 40 == 0) send_gaps = ($urandom_range(0, 3) != 0);
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  function automatic logic [7:0] rand_letter();
    return $urandom_range(0, 1) ? 8'($urandom_range("a", "z")) : 8'($urandom_range("A", "Z"));
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'("0" + $urandom_range(0, 9));
  endfunction

  // letter, digit or underscore: anything that keeps a word going
  function automatic logic [7:0] rand_word_char();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) return rand_letter();
    if (pick < 9) return rand_digit();
    return "_";
  endfunction

  // One line of mostly well-formed tokens with random content, a little noise,
  // and random separators (often none, so tokens butt against each other and
  // one character closes one token and opens the next). Ends with LF or CR.
  task automatic send_random_line();
    int         n_tok;
    int         pick;
    int         len;
    int         k;
    bit         open_string;
    string      kw;
    logic [7:0] c;
    n_tok       = $urandom_range(1, 10);
    open_string = 1'b0;
    repeat (n_tok) begin
      if (!open_string) begin
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
          // integer or decimal: a digit, then digits with the odd dot
          send_char(rand_digit());
          len = $urandom_range(0, 6);
          repeat (len) send_char(($urandom_range(0, 4) == 0) ? 8'(".") : rand_digit());
        end else if (pick < 30) begin
          send_char(rand_letter());
          len = $urandom_range(0, 7);
          repeat (len) send_char(rand_word_char());
        end else if (pick < 45) begin
          // function names, exact or near misses (extra char, clipped)
          kw = kw_names[$urandom_range(0, 6)];
          if ($urandom_range(0, 7) == 0) kw = kw.substr(0, kw.len() - 2);
          send_text(kw);
          if ($urandom_range(0, 3) == 0) send_char(rand_word_char());
        end else if (pick < 55) begin
          // quoted string; sometimes left open so the newline cuts it off
          send_char("\"");
          len = $urandom_range(0, 8);
          for (k = 0; k < len; k++) begin
            c = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(128, 255))
                                             : 8'($urandom_range(32, 126));
            if (c == "\"") c = "'";
            send_char(c);
          end
          if ($urandom_range(0, 7) == 0) open_string = 1'b1;
          else send_char("\"");
        end else if (pick < 85) begin
          if ($urandom_range(0, 2) == 0) send_text(op_pairs[$urandom_range(0, 3)]);
          else send_char(op_chars[$urandom_range(0, op_chars.len() - 1)]);
        end else if (pick < 92) begin
          // raw noise byte, any value
          send_char(8'($urandom_range(0, 255)));
        end else begin
          len = $urandom_range(1, 4);
          repeat (len) send_char($urandom_range(0, 1) ? CH_TAB : 8'(" "));
        end
        if (!open_string) begin
          len = $urandom_range(0, 2);
          repeat (len) send_char($urandom_range(0, 1) ? CH_TAB : 8'(" "));
        end
      end
    end
    send_char($urandom_range(0, 1) ? CH_LF : CH_CR);
  endtask

  // Stimulus and verdict.
  initial begin
    int base;
    int k;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: every one- and two-character operator, the lone-operator forms,
    // a lone bar followed by a parenthesis (two tokens from one character), every
    // bracket and punctuation token, a string cut off by a newline, unknown
    // bytes (0xFF, NUL, a lone dot) and a CR newline.
    send_text("===>=><=<|||()[]^+-*/,\"a\n");
    send_char(8'hFF);
    send_char(8'h00);
    send_char(".");
    send_char(CH_CR);

    // Random lines.
    send_gaps = 1'b1;
    base = chars_sent;
    while (chars_sent - base < 750) send_random_line();
    in_valid <= 1'b0;
    @(posedge clk);

    // Drain: wait for every predicted token, bounded, then let the pipe settle.
    for (k = 0; k < 20000 && tokens_owed != 0; k++) @(posedge clk);
    repeat (20) @(posedge clk);

    if (fail_count == 0 && tokens_owed == 0) begin
      $display("expression_tokenizer_top_tb: PASS");
    end else begin
      if (tokens_owed != 0) $display("%0d predicted tokens never came out", tokens_owed);
      $display("expression_tokenizer_top_tb: FAIL");
    end
    $finish;
  end

  // Token receiver. Draws a stall per transaction and switches stalling on and
  // off in stretches. Twice it holds off while the sender keeps offering
  // characters, so the block fills and stalls its input.
  initial begin
    int  n;
    int  taken;
    bit  recv_gaps;
    taken     = 0;
    recv_gaps = 1'b0;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (taken % 30 == 0) recv_gaps = ($urandom_range(0, 3) != 0);
      if (taken == 40 || taken == 250) n = 300;
      else n = recv_gaps ? $urandom_range(0, 14) : 0;
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      // out_stall is low here, so any valid token at the edge is taken
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
    end
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("expression_tokenizer_top_tb: FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/exptok_pkg.sv
rtl/exptok_lexer.sv
rtl/exptok_fifo.sv
rtl/expression_tokenizer_top.sv
dv/expression_tokenizer_checker.sv
dv/expression_tokenizer_top_tb.sv
